>>> rtl/core/psched_pkg.sv
// Package with the types, sizes and codes shared by the scheduler modules.
`default_nettype none

package psched_pkg;

  // Number of task slots held in the table.
  localparam int unsigned SLOTS = 16;

  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);
  localparam int unsigned CFG_W = 5;
  localparam int unsigned SLOT_W = 4;
  localparam int unsigned TIME_W = 16;
  localparam int unsigned PRIO_W = 8;

  // Compare widths wide enough for both operands.
  localparam int unsigned SLOT_CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
  localparam int unsigned CLAMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(16);

  // Input transaction kinds.
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] arrival_tick;
    logic [TIME_W-1:0] burst_ticks;
    logic [PRIO_W-1:0] task_priority;
  } in_t;

  typedef struct packed {
    logic [SLOT_W-1:0] running_slot;
    logic              idle;
    logic [TIME_W-1:0] time_now;
    logic              finished;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
    logic              all_done;
  } out_t;

  // One row of the task table.
  typedef struct packed {
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic [TIME_W-1:0] remaining;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic load_wr;
    logic scan_rd;
    logic update;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
  } stat_t;

endpackage

`default_nettype wire

>>> rtl/core/psched_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none

module psched_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

>>> rtl/core/psched_ctrl.sv
// Controller state machine that sequences loads and tick scans.
`default_nettype none

module psched_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic              kind_i,
  input  wire psched_pkg::stat_t stat_i,
  output psched_pkg::cmd_t       cmd_o,
  output logic                   busy_o
);

  import psched_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d = (kind_i == KIND_TICK) ? ST_SCAN : ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.load_wr = 1'b1;
        state_d = ST_IDLE;
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (stat_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/psched_dp.sv
// Datapath: task table, slot scan and compare, tick update and result register.
`default_nettype none

module psched_dp (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire psched_pkg::cmd_t                  cmd_i,
  input  wire psched_pkg::in_t                   in_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [psched_pkg::CFG_W-1:0]      cfg_data_i,
  output psched_pkg::stat_t                      stat_o,
  output logic                                   res_valid_o,
  output psched_pkg::out_t                       res_o
);

  import psched_pkg::*;

  in_t               in_q;
  logic [CFG_W-1:0]  active_q;
  logic [IDX_W-1:0]  cnt_q, cnt_d;
  logic              cmp_vld_q;
  logic [IDX_W-1:0]  cmp_idx_q;
  logic              found_q, found_d;
  entry_t            best_q, best_d;
  logic [IDX_W-1:0]  best_idx_q, best_idx_d;
  logic [SLOTS-1:0]  done_q, done_d;
  logic [TIME_W-1:0] tick_q, tick_d;
  logic              res_vld_q;
  out_t              res_q, res_d;

  logic [CLAMP_W-1:0] active_ext;
  logic [CNT_W-1:0]   n_active;
  logic [SLOTS-1:0]   act_mask;
  logic               slot_ok;

  logic [IDX_W-1:0]   ram_addr;
  logic               ram_we;
  entry_t             ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             rd_ent;

  logic               elig, better;
  logic [TIME_W-1:0]  tick_next, rem_new, tat, wt;
  logic               fin;

  // Active slot count, clamped to one through SLOTS.
  always_comb begin
    active_ext = CLAMP_W'(active_q);
    if (active_ext == '0) begin
      n_active = CNT_W'(1);
    end else if (active_ext > CLAMP_W'(SLOTS)) begin
      n_active = CNT_W'(SLOTS);
    end else begin
      n_active = CNT_W'(active_ext);
    end
  end

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      act_mask[i] = (CNT_W'(i) < n_active);
    end
  end

  assign stat_o.scan_last = (CNT_W'(cnt_q) == (n_active - CNT_W'(1)));
  assign slot_ok = (SLOT_CMP_W'(in_q.slot) < SLOT_CMP_W'(SLOTS));

  // Table memory: one row per slot.
  always_comb begin
    ram_addr  = cnt_q;
    ram_we    = 1'b0;
    ram_wdata = best_q;
    ram_wdata.remaining = rem_new;
    if (cmd_i.load_wr) begin
      ram_addr  = IDX_W'(in_q.slot);
      ram_we    = slot_ok;
      ram_wdata.arrival   = in_q.arrival_tick;
      ram_wdata.burst     = in_q.burst_ticks;
      ram_wdata.remaining = in_q.burst_ticks;
      ram_wdata.prio      = in_q.task_priority;
    end else if (cmd_i.update) begin
      ram_addr = best_idx_q;
      ram_we   = found_q;
    end
  end

  psched_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign rd_ent = entry_t'(ram_rdata);

  // Compare the row read last cycle against the best so far. Strict compares
  // leave ties with the lower slot, since slots are read in ascending order.
  assign elig = cmp_vld_q && !done_q[cmp_idx_q] && (rd_ent.arrival <= tick_q);
  assign better = !found_q || (rd_ent.prio < best_q.prio) ||
                  ((rd_ent.prio == best_q.prio) && (rd_ent.remaining < best_q.remaining));

  assign tick_next = (tick_q == TIME_MAX) ? tick_q : tick_q + TIME_W'(1);
  assign rem_new   = (best_q.remaining == '0) ? '0 : best_q.remaining - TIME_W'(1);
  assign fin       = found_q && (best_q.remaining <= TIME_W'(1));
  assign tat       = tick_next - best_q.arrival;
  assign wt        = (tat >= best_q.burst) ? tat - best_q.burst : '0;

  always_comb begin
    cnt_d      = cnt_q;
    found_d    = found_q;
    best_d     = best_q;
    best_idx_d = best_idx_q;
    done_d     = done_q;
    tick_d     = tick_q;
    res_d      = res_q;

    if (cmd_i.capture) begin
      cnt_d   = '0;
      found_d = 1'b0;
    end
    if (cmd_i.scan_rd) begin
      cnt_d = cnt_q + IDX_W'(1);
    end
    if (elig && better) begin
      best_d     = rd_ent;
      best_idx_d = cmp_idx_q;
      found_d    = 1'b1;
    end
    if (cmd_i.load_wr && slot_ok) begin
      done_d[IDX_W'(in_q.slot)] = 1'b0;
    end
    if (cmd_i.update) begin
      tick_d = tick_next;
      if (fin) begin
        done_d[best_idx_q] = 1'b1;
      end
      res_d.running_slot = found_q ? SLOT_W'(best_idx_q) : '0;
      res_d.idle         = !found_q;
      res_d.time_now     = tick_next;
      res_d.finished     = fin;
      res_d.turnaround   = fin ? tat : '0;
      res_d.waiting      = fin ? wt : '0;
      res_d.all_done     = &(done_d | ~act_mask);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= ACTIVE_RESET;
      cmp_vld_q <= 1'b0;
      found_q   <= 1'b0;
      done_q    <= '0;
      tick_q    <= '0;
      res_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        active_q <= cfg_data_i;
      end
      cmp_vld_q <= cmd_i.scan_rd;
      found_q   <= found_d;
      done_q    <= done_d;
      tick_q    <= tick_d;
      res_vld_q <= cmd_i.update;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_q <= in_i;
    end
    cnt_q      <= cnt_d;
    cmp_idx_q  <= cnt_q;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    res_q      <= res_d;
  end

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

  // A result follows the update cycle and no other.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |-> $past(cmd_i.update))
    else $error("result strobe without an update cycle");

  // A finished task must have run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && res_q.finished) |-> !res_q.idle)
    else $error("finished reported on an idle tick");

  // An idle tick reports slot zero and no completion.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && res_q.idle) |-> ((res_q.running_slot == '0) && !res_q.finished))
    else $error("idle tick carries a slot or a completion");

  // Every tick leaves the time at one or more.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |-> (res_q.time_now != '0))
    else $error("time did not advance on a tick");

  // The time changes only on an update.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(cmd_i.update) |-> $stable(tick_q))
    else $error("time changed outside an update");

endmodule

`default_nettype wire

>>> rtl/core/preemptive_priority_scheduler.sv
// Top level of the preemptive priority scheduler: controller plus datapath.
//
//   Channel   Ports                          Transaction
//   -------   ----------------------------   --------------------------------------
//   command   start, busy, in_i              start high while busy is low
//   result    res_valid_o, res_o             res_valid_o high for one cycle
//   config    cfg_valid_i, cfg_ready_o,      cfg_valid_i and cfg_ready_o high
//             cfg_data_i
//
// A load transaction keeps busy high for one cycle after it is taken and gives
// no result. A tick transaction keeps busy high while the slot scan reads the
// clamped active slot count of table rows, one row per cycle from the
// single-port table memory, and then through a drain and an update state. The
// result strobe is shown in the first cycle in which busy is low again.
// The receiver cannot stall the result, and a new command may be taken while
// the result strobe is shown. Reset is asynchronous and active low; it clears
// the done marks, the time and the active slot count (back to 16) but leaves
// the table contents undefined.
`default_nettype none

module preemptive_priority_scheduler (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire psched_pkg::in_t              in_i,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [psched_pkg::CFG_W-1:0] cfg_data_i,
  output logic                              res_valid_o,
  output psched_pkg::out_t                  res_o
);

  import psched_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // The controller only steps the datapath; all table state lives below it.
  psched_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .kind_i  (in_i.kind),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  // Configuration is taken only between transactions so that a scan always
  // sees one slot count from start to end.
  assign cfg_ready_o = !busy;

  psched_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_i        (in_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .stat_o      (stat),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire

>>> sim/preemptive_priority_scheduler_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the preemptive priority scheduler: directed table, random phases.

module preemptive_priority_scheduler_tb;
  import psched_pkg::*;

  // Longest random pause of the sender between two command transactions.
  localparam int unsigned MAX_GAP = 4;
  // Random part: one active slot setting per phase.
  localparam int unsigned RANDOM_PHASES = 10;
  localparam int unsigned PHASE_ITEMS = 153;
  // Cycles allowed after the last tick report before the block counts as idle.
  // A load gives no report and keeps busy high for one cycle only.
  localparam int unsigned SETTLE_CYCLES = 4;
  // A tick scans the clamped active slots, then drains and updates, so this is ample.
  localparam int unsigned DRAIN_LIMIT = 4 * (SLOTS + 8);
  localparam int unsigned MAX_PRINTED = 50;

  // One row of the directed table. When typed is set, the report is the
  // expected result written out by hand; otherwise the predictor decides.
  typedef struct packed {
    in_t  cmd;
    logic typed;
    out_t report;
  } stim_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  in_t              cmd_in;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i;
  logic             res_valid_o;
  out_t             res_o;

  // Shadow copy of the scheduler state, kept up to date at every accepted
  // transaction.
  logic [TIME_W-1:0] slot_arrival   [SLOTS];
  logic [TIME_W-1:0] slot_burst     [SLOTS];
  logic [TIME_W-1:0] slot_remaining [SLOTS];
  logic [PRIO_W-1:0] slot_prio      [SLOTS];
  bit                slot_done      [SLOTS];
  // Slots that hold data. No tick is sent while an active slot is empty,
  // because its table row would still be undefined.
  bit                slot_loaded    [SLOTS];
  logic [TIME_W-1:0] sched_time;
  int unsigned       sched_active;

  // Tick reports that the block still owes, oldest first.
  out_t        tick_reports_q [$];
  int unsigned mismatch_count;

  logic [CFG_W-1:0] cfg_plan [6];

  preemptive_priority_scheduler u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_i        (cmd_in),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs. The slowest correct run stays well
  // below a millisecond.
  initial begin
    #5_000_000;
    $display("preemptive_priority_scheduler_tb failed");
    $finish;
  end

  // Each mismatch prints one line, up to a cap, and is always counted.
  task automatic report_mismatch(input string what, input logic [TIME_W-1:0] got,
                                 input logic [TIME_W-1:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) begin
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    end
  endtask

  // The register value 0 acts as one slot and anything above SLOTS as SLOTS.
  function automatic int unsigned effective_slots(input logic [CFG_W-1:0] value);
    if (value == '0) return 1;
    if (value > SLOTS) return SLOTS;
    return 32'(value);
  endfunction

  // A load rewrites one slot and clears its done mark, so a finished task
  // can be brought back to life.
  task automatic sched_load(input in_t item);
    slot_arrival[item.slot]   = item.arrival_tick;
    slot_burst[item.slot]     = item.burst_ticks;
    slot_remaining[item.slot] = item.burst_ticks;
    slot_prio[item.slot]      = item.task_priority;
    slot_done[item.slot]      = 1'b0;
    slot_loaded[item.slot]    = 1'b1;
  endtask

  // One tick: pick the winner among the arrived, unfinished active slots,
  // advance the time and build the report the block has to produce.
  task automatic sched_tick(output out_t report);
    int unsigned       idx;
    int unsigned       best;
    bit                found;
    logic [TIME_W-1:0] rem;
    logic [TIME_W-1:0] tat;
    best  = 0;
    found = 1'b0;
    for (idx = 0; idx < sched_active; idx++) begin
      if (!slot_done[idx] && slot_arrival[idx] <= sched_time) begin
        // Lowest priority number first, then less remaining work. The
        // strict compares leave a full tie with the lower index.
        if (!found || slot_prio[idx] < slot_prio[best] ||
            (slot_prio[idx] == slot_prio[best] &&
             slot_remaining[idx] < slot_remaining[best])) begin
          best  = idx;
          found = 1'b1;
        end
      end
    end

    // The time stops at its maximum instead of wrapping.
    if (sched_time != TIME_MAX) sched_time = sched_time + 1'b1;

    report          = '0;
    report.idle     = 1'b1;
    report.time_now = sched_time;
    if (found) begin
      rem                  = slot_remaining[best];
      report.running_slot  = SLOT_W'(best);
      report.idle          = 1'b0;
      slot_remaining[best] = (rem != '0) ? rem - 1'b1 : '0;
      // A burst of zero still runs one tick and completes on it.
      if (rem <= 1) begin
        slot_done[best]   = 1'b1;
        tat               = sched_time - slot_arrival[best];
        report.finished   = 1'b1;
        report.turnaround = tat;
        // Once the time has saturated the waiting time could go negative;
        // it is clamped to zero.
        report.waiting    = (tat >= slot_burst[best]) ? tat - slot_burst[best] : '0;
      end
    end

    report.all_done = 1'b1;
    for (idx = 0; idx < sched_active; idx++) begin
      if (!slot_done[idx]) report.all_done = 1'b0;
    end
  endtask

  // Offer one command transaction after a pause of gap cycles and wait until
  // the block takes it. Start stays high across back-to-back transactions.
  task automatic issue_cmd(input in_t item, input int unsigned gap, input logic typed,
                           input out_t typed_report);
    out_t report;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start  <= 1'b1;
    cmd_in <= item;
    do @(posedge clk_i); while (busy);
    if (item.kind == KIND_LOAD) begin
      sched_load(item);
    end else begin
      sched_tick(report);
      tick_reports_q.push_back(typed ? typed_report : report);
    end
  endtask

  task automatic send_load(input int unsigned slot, input logic [TIME_W-1:0] arrival,
                           input logic [TIME_W-1:0] burst, input logic [PRIO_W-1:0] prio,
                           input int unsigned gap);
    in_t item;
    item.kind          = KIND_LOAD;
    item.slot          = SLOT_W'(slot);
    item.arrival_tick  = arrival;
    item.burst_ticks   = burst;
    item.task_priority = prio;
    issue_cmd(item, gap, 1'b0, '0);
  endtask

  // The load fields of a tick are don't-care, so they carry random noise.
  task automatic send_tick(input int unsigned gap);
    in_t item;
    item.kind          = KIND_TICK;
    item.slot          = SLOT_W'($urandom);
    item.arrival_tick  = TIME_W'($urandom);
    item.burst_ticks   = TIME_W'($urandom);
    item.task_priority = PRIO_W'($urandom);
    issue_cmd(item, gap, 1'b0, '0);
  endtask

  task automatic wait_for_drain(input int unsigned limit);
    int unsigned waited;
    waited = 0;
    while (tick_reports_q.size() != 0 && waited < limit) begin
      @(posedge clk_i);
      waited++;
    end
  endtask

  // Stop sending, let every owed report arrive and give a trailing load
  // time to finish, so that the block is idle afterwards.
  task automatic hold_until_drained();
    start <= 1'b0;
    wait_for_drain(DRAIN_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register writes happen only while the block is idle.
  task automatic write_active_slots(input logic [CFG_W-1:0] value);
    hold_until_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i  <= 1'b0;
    sched_active = effective_slots(value);
  endtask

  // Arrival ticks cluster around the current time so that most loaded tasks
  // actually run; a few are drawn from the whole range.
  function automatic logic [TIME_W-1:0] pick_arrival();
    int near;
    if ($urandom_range(0, 11) == 0) return TIME_W'($urandom);
    near = int'(sched_time) + int'($urandom_range(0, 12)) - 4;
    if (near < 0) near = 0;
    if (near > int'(TIME_MAX)) near = int'(TIME_MAX);
    return TIME_W'(near);
  endfunction

  function automatic stim_row_t load_row(input int unsigned slot,
                                         input logic [TIME_W-1:0] arrival,
                                         input logic [TIME_W-1:0] burst,
                                         input logic [PRIO_W-1:0] prio);
    stim_row_t row;
    row                    = '0;
    row.cmd.kind           = KIND_LOAD;
    row.cmd.slot           = SLOT_W'(slot);
    row.cmd.arrival_tick   = arrival;
    row.cmd.burst_ticks    = burst;
    row.cmd.task_priority  = prio;
    return row;
  endfunction

  // A tick row left to the predictor.
  function automatic stim_row_t free_tick_row();
    stim_row_t row;
    row          = '0;
    row.cmd.kind = KIND_TICK;
    return row;
  endfunction

  // A tick row with its report written out by hand.
  function automatic stim_row_t tick_row(input int unsigned running, input logic idle,
                                         input logic [TIME_W-1:0] now, input logic fin,
                                         input logic [TIME_W-1:0] tat,
                                         input logic [TIME_W-1:0] wt, input logic all_done);
    stim_row_t row;
    row                     = free_tick_row();
    row.typed               = 1'b1;
    row.report.running_slot = SLOT_W'(running);
    row.report.idle         = idle;
    row.report.time_now     = now;
    row.report.finished     = fin;
    row.report.turnaround   = tat;
    row.report.waiting      = wt;
    row.report.all_done     = all_done;
    return row;
  endfunction

  // Every report strobe is checked against the oldest owed report. Sampling
  // at the rising edge sees the values of the cycle that the edge ends.
  always @(posedge clk_i) begin : check_reports
    out_t want;
    if (rst_ni && res_valid_o) begin
      if (tick_reports_q.size() == 0) begin
        report_mismatch("report with no tick pending, time_now", res_o.time_now, '0);
      end else begin
        want = tick_reports_q.pop_front();
        if (res_o.running_slot !== want.running_slot)
          report_mismatch("running_slot", TIME_W'(res_o.running_slot),
                          TIME_W'(want.running_slot));
        if (res_o.idle !== want.idle)
          report_mismatch("idle", TIME_W'(res_o.idle), TIME_W'(want.idle));
        if (res_o.time_now !== want.time_now)
          report_mismatch("time_now", res_o.time_now, want.time_now);
        if (res_o.finished !== want.finished)
          report_mismatch("finished", TIME_W'(res_o.finished), TIME_W'(want.finished));
        if (res_o.turnaround !== want.turnaround)
          report_mismatch("turnaround", res_o.turnaround, want.turnaround);
        if (res_o.waiting !== want.waiting)
          report_mismatch("waiting", res_o.waiting, want.waiting);
        if (res_o.all_done !== want.all_done)
          report_mismatch("all_done", TIME_W'(res_o.all_done), TIME_W'(want.all_done));
      end
    end
  end

  initial begin : stimulus
    stim_row_t        directed_rows [$];
    stim_row_t        row;
    int unsigned      phase;
    int unsigned      n;
    int unsigned      idx;
    int unsigned      gap;
    int unsigned      slot;
    int unsigned      r;
    logic             no_idle;
    logic [CFG_W-1:0] cfg_value;

    // Every input is known from time zero, while reset is held low.
    rst_ni         = 1'b0;
    start          = 1'b0;
    cmd_in         = '0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    mismatch_count = 0;
    sched_time     = '0;
    sched_active   = effective_slots(ACTIVE_RESET);
    for (idx = 0; idx < SLOTS; idx++) begin
      slot_done[idx]   = 1'b0;
      slot_loaded[idx] = 1'b0;
    end
    // Register settings of the first random phases: the reset value, both
    // ends of the legal range and the out-of-range values on either side.
    cfg_plan = '{CFG_W'(16), CFG_W'(1), CFG_W'(0), CFG_W'(31), CFG_W'(17), CFG_W'(2)};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed part, with two active slots so that the expected reports can
    // be worked out by hand. It covers a zero burst, the field extremes, an
    // idle tick before arrival, reload of a done slot, both tie breaks,
    // preemption by a later high-priority arrival and ticks after all done.
    write_active_slots(CFG_W'(2));
    directed_rows.push_back(load_row(0, 16'd0, 16'd0, 8'd0));
    directed_rows.push_back(load_row(1, TIME_MAX, TIME_MAX, 8'd255));
    directed_rows.push_back(tick_row(0, 1'b0, 16'd1, 1'b1, 16'd1, 16'd1, 1'b0));
    directed_rows.push_back(tick_row(0, 1'b1, 16'd2, 1'b0, 16'd0, 16'd0, 1'b0));
    directed_rows.push_back(load_row(0, 16'd1, 16'd2, 8'd5));
    directed_rows.push_back(load_row(1, 16'd0, 16'd1, 8'd5));
    directed_rows.push_back(tick_row(1, 1'b0, 16'd3, 1'b1, 16'd3, 16'd2, 1'b0));
    directed_rows.push_back(tick_row(0, 1'b0, 16'd4, 1'b0, 16'd0, 16'd0, 1'b0));
    directed_rows.push_back(tick_row(0, 1'b0, 16'd5, 1'b1, 16'd4, 16'd2, 1'b1));
    directed_rows.push_back(tick_row(0, 1'b1, 16'd6, 1'b0, 16'd0, 16'd0, 1'b1));
    directed_rows.push_back(load_row(0, 16'd0, 16'd1, 8'd7));
    directed_rows.push_back(load_row(1, 16'd0, 16'd1, 8'd7));
    directed_rows.push_back(tick_row(0, 1'b0, 16'd7, 1'b1, 16'd7, 16'd6, 1'b0));
    directed_rows.push_back(tick_row(1, 1'b0, 16'd8, 1'b1, 16'd8, 16'd7, 1'b1));
    directed_rows.push_back(load_row(0, 16'd0, 16'd3, 8'd9));
    directed_rows.push_back(load_row(1, 16'd10, 16'd1, 8'd1));
    directed_rows.push_back(free_tick_row());
    directed_rows.push_back(free_tick_row());
    directed_rows.push_back(free_tick_row());
    directed_rows.push_back(free_tick_row());
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      issue_cmd(row.cmd, $urandom_range(0, MAX_GAP), row.typed, row.report);
    end

    // Random part. Each phase sets a new slot count, fills any active slot
    // that still has no data, then mixes loads near the current time with a
    // majority of ticks. Some phases leave no gaps between commands but for drain waits.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      cfg_value = (phase < 6) ? cfg_plan[phase] : CFG_W'($urandom_range(0, 31));
      write_active_slots(cfg_value);
      no_idle = ($urandom_range(0, 3) == 0);
      for (idx = 0; idx < sched_active; idx++) begin
        if (!slot_loaded[idx]) begin
          send_load(idx, pick_arrival(), TIME_W'($urandom_range(0, 6)),
                    PRIO_W'($urandom_range(0, 3)), no_idle ? 0 : $urandom_range(0, MAX_GAP));
        end
      end
      for (n = 0; n < PHASE_ITEMS; n++) begin
        r   = $urandom_range(0, 99);
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        // Now and then the sender waits for every owed report first.
        if (r == 99) hold_until_drained();
        if (r < 30) begin
          // Mostly loads into the active slots; some go to any slot, also outside them.
          slot = (r < 26) ? $urandom_range(0, sched_active - 1) : $urandom_range(0, SLOTS - 1);
          send_load(slot, pick_arrival(),
                    ($urandom_range(0, 11) == 0) ? TIME_W'($urandom)
                                                 : TIME_W'($urandom_range(0, 6)),
                    ($urandom_range(0, 9) == 0) ? PRIO_W'($urandom)
                                                : PRIO_W'($urandom_range(0, 3)),
                    gap);
        end else begin
          send_tick(gap);
        end
      end
    end

    // Collect the last reports, then watch a little longer for stray ones.
    start <= 1'b0;
    wait_for_drain(DRAIN_LIMIT);
    if (tick_reports_q.size() != 0) begin
      report_mismatch("tick reports never delivered", TIME_W'(tick_reports_q.size()), '0);
    end
    repeat (DRAIN_LIMIT) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("preemptive_priority_scheduler_tb passed");
    end else begin
      $display("preemptive_priority_scheduler_tb failed");
    end
    $finish;
  end

endmodule

>>> preemptive_priority_scheduler.f
rtl/core/psched_pkg.sv
rtl/core/psched_ram.sv
rtl/core/psched_ctrl.sv
rtl/core/psched_dp.sv
rtl/core/preemptive_priority_scheduler.sv
sim/preemptive_priority_scheduler_tb.sv
